// ===== sv/clw_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and constant tables for the Chebyshev-Lagrange weight block.
// The node table and the inverse denominator table are built at elaboration.
// Depends on nothing.
package clw_pkg;

  localparam int MAX_NODES = 8;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int ROM_DEPTH = 1 << (2 * IDX_W);
  localparam int QUOT_W    = 39;

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
  localparam logic [63:0] PROD_CAP = 64'd1 << 62;
  localparam logic [63:0] TAYLOR_DIV [8] = '{64'd2, 64'd12, 64'd30, 64'd56,
                                             64'd90, 64'd132, 64'd182, 64'd240};

  typedef logic [ROM_DEPTH-1:0][31:0] rom_t;

  typedef enum logic [1:0] {
    OUT_NONE,
    OUT_CALC,
    OUT_UNIT,
    OUT_EMPTY
  } out_kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SPECIAL,
    S_DIV,
    S_TLOAD,
    S_INIT,
    S_OPLOAD,
    S_MUL,
    S_NORM,
    S_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic             load;
    logic             div_step;
    logic             t_take;
    logic             acc_init;
    logic             op_load;
    logic             op_inv;
    logic             pp_step;
    logic [1:0]       pp_idx;
    logic             acc_update;
    out_kind_e        out_kind;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] k;
    logic             last;
  } dp_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             single;
    logic             empty;
  } dp_stat_t;

  // Unsigned quotient by restoring long division, used only while the tables
  // are built.
  function automatic logic [63:0] udiv_c(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], n[b]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Cosine of pi*k/(2r) in Q30, truncated Taylor series.
  function automatic logic signed [63:0] cos_q30(input int k, input int r);
    logic [63:0] p;
    logic [63:0] phi;
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    p    = PI_Q30 * 64'(k);
    phi  = udiv_c(p, 64'(2 * r));
    x2   = (phi * phi) >> 30;
    term = ONE_Q30;
    sum  = signed'(ONE_Q30);
    for (int n = 1; n <= 8; n++) begin
      term = udiv_c((term * x2) >> 30, TAYLOR_DIV[n-1]);
      if ((n & 1) == 1) sum = sum - signed'(term);
      else sum = sum + signed'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > signed'(ONE_Q30)) sum = signed'(ONE_Q30);
    return sum;
  endfunction

  function automatic logic signed [63:0] node_val(input int i, input int r);
    int m;
    m = 2 * i + 1;
    if (m < r) return cos_q30(m, r);
    else if (m == r) return 64'sd0;
    else return -cos_q30(2 * r - m, r);
  endfunction

  function automatic logic signed [63:0] mulq_c(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [127:0] p;
    logic [127:0] res;
    ua  = a < 0 ? 64'(-a) : 64'(a);
    ub  = b < 0 ? 64'(-b) : 64'(b);
    p   = {64'd0, ua} * {64'd0, ub};
    res = p >> 30;
    if (res > {64'd0, PROD_CAP}) res = {64'd0, PROD_CAP};
    return ((a < 0) != (b < 0)) ? -signed'(res[63:0]) : signed'(res[63:0]);
  endfunction

  function automatic rom_t build_nodes();
    rom_t t;
    t = '0;
    for (int r = 1; r <= MAX_NODES; r++) begin
      for (int i = 0; i < r; i++) begin
        t[(r - 1) * MAX_NODES + i] = 32'(node_val(i, r));
      end
    end
    return t;
  endfunction

  function automatic rom_t build_inv();
    rom_t t;
    logic signed [63:0] d;
    logic [63:0] ud;
    logic [63:0] inv;
    t = '0;
    for (int r = 1; r <= MAX_NODES; r++) begin
      for (int i = 0; i < r; i++) begin
        d = signed'(ONE_Q30);
        for (int k = 0; k < r; k++) begin
          if (k != i) d = mulq_c(d, node_val(i, r) - node_val(k, r));
        end
        ud = d < 0 ? 64'(-d) : 64'(d);
        if (ud != 0) begin
          inv = udiv_c((64'd1 << 50) + (ud >> 1), ud);
          if (inv > 64'h7FFF_FFFF) inv = 64'h7FFF_FFFF;
          t[(r - 1) * MAX_NODES + i] = d < 0 ? 32'(-signed'(inv)) : inv[31:0];
        end
      end
    end
    return t;
  endfunction

  localparam rom_t NODE_ROM = build_nodes();
  localparam rom_t INV_ROM  = build_inv();

endpackage

// ===== sv/clw_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for the weight block: division, product loop and result strobes.
// Depends on clw_pkg.
module clw_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  clw_pkg::dp_stat_t  stat_i,
  output logic               busy_o,
  output clw_pkg::dp_cmd_t   cmd_o
);
  import clw_pkg::*;

  ctrl_state_e state_q, state_d;
  logic [IDX_W-1:0] j_q, k_q;
  logic             inv_q;
  logic [5:0]       div_cnt_q;
  logic [1:0]       pp_q;
  logic             last_w, k_end, skip;

  assign last_w = (CNT_W'(j_q) + CNT_W'(1)) == stat_i.count;
  assign k_end  = (CNT_W'(k_q) + CNT_W'(1)) == stat_i.count;
  assign skip   = !inv_q && (k_q == j_q);
  assign busy_o = state_q != S_IDLE;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:    if (start_i) state_d = (stat_i.single || stat_i.empty) ? S_SPECIAL : S_DIV;
      S_SPECIAL: if (last_w) state_d = S_IDLE;
      S_DIV:     if (div_cnt_q == 6'(QUOT_W - 1)) state_d = S_TLOAD;
      S_TLOAD:   state_d = S_INIT;
      S_INIT:    state_d = S_OPLOAD;
      S_OPLOAD:  if (!skip) state_d = S_MUL;
      S_MUL:     if (pp_q == 2'd3) state_d = S_NORM;
      S_NORM:    state_d = inv_q ? S_EMIT : S_OPLOAD;
      S_EMIT:    state_d = last_w ? S_IDLE : S_INIT;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.out_kind   = OUT_NONE;
    cmd_o.j          = j_q;
    cmd_o.k          = k_q;
    cmd_o.last       = last_w;
    cmd_o.op_inv     = inv_q;
    cmd_o.pp_idx     = pp_q;
    case (state_q)
      S_IDLE:    cmd_o.load = start_i;
      S_SPECIAL: cmd_o.out_kind = stat_i.single ? OUT_UNIT : OUT_EMPTY;
      S_DIV:     cmd_o.div_step = 1'b1;
      S_TLOAD:   cmd_o.t_take = 1'b1;
      S_INIT:    cmd_o.acc_init = 1'b1;
      S_OPLOAD:  cmd_o.op_load = !skip;
      S_MUL:     cmd_o.pp_step = 1'b1;
      S_NORM:    cmd_o.acc_update = 1'b1;
      S_EMIT:    cmd_o.out_kind = OUT_CALC;
      default:   cmd_o.out_kind = OUT_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      j_q       <= '0;
      k_q       <= '0;
      inv_q     <= 1'b0;
      div_cnt_q <= '0;
      pp_q      <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: begin
          j_q       <= '0;
          div_cnt_q <= '0;
        end
        S_SPECIAL: if (!last_w) j_q <= j_q + 1'b1;
        S_DIV:     div_cnt_q <= div_cnt_q + 6'd1;
        S_INIT: begin
          k_q   <= '0;
          inv_q <= 1'b0;
        end
        S_OPLOAD: begin
          if (skip) begin
            if (k_end) inv_q <= 1'b1;
            else k_q <= k_q + 1'b1;
          end
        end
        S_MUL:  pp_q <= pp_q + 2'd1;
        S_NORM: begin
          if (!inv_q) begin
            if (k_end) inv_q <= 1'b1;
            else k_q <= k_q + 1'b1;
          end
        end
        S_EMIT:  if (!last_w) j_q <= j_q + 1'b1;
        default: j_q <= j_q;
      endcase
    end
  end

  a_start_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && start_i) |=> (state_q != S_IDLE))
    else $error("accepted item did not leave idle");

  a_last_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.out_kind != OUT_NONE && cmd_o.last) |=> (state_q == S_IDLE))
    else $error("final weight not followed by idle");

  a_pp_only_in_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_MUL) |-> (pp_q == 2'd0))
    else $error("partial product counter left running");

  a_node_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (CNT_W'(j_q) < stat_i.count))
    else $error("node index beyond node count");

endmodule

// ===== sv/clw_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: normalised coordinate divider, shared 32x32 multiplier with product
// accumulator, node and denominator tables, result registers. Depends on clw_pkg.
module clw_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  clw_pkg::dp_cmd_t    cmd_i,
  input  logic signed [31:0]  interval_low_i,
  input  logic signed [31:0]  interval_high_i,
  input  logic [3:0]          node_count_i,
  input  logic signed [31:0]  point_value_i,
  output clw_pkg::dp_stat_t   stat_o,
  output logic                result_valid_o,
  output logic signed [31:0]  weight_o,
  output logic [2:0]          node_index_o,
  output logic                saturated_o,
  output logic                last_o
);
  import clw_pkg::*;

  logic [CNT_W-1:0] count_w;
  logic [IDX_W-1:0] rm1;
  logic signed [32:0] den_w;
  logic signed [34:0] num_w, num_a;
  logic [32:0] den_mag;
  logic [33:0] na;

  // Divider state
  logic [32:0]        den_q, rem_q, rem_d;
  logic [QUOT_W-1:0]  dsh_q, quot_q;
  logic               neg_q, clamp_q;
  logic [33:0]        trial;
  logic               ge;
  logic signed [40:0] t_q;
  logic [39:0]        tabs;

  // Product loop state
  logic [62:0]  acc_mag_q;
  logic         acc_neg_q;
  logic [41:0]  op_mag_q;
  logic         op_neg_q;
  logic [104:0] prod_q;
  logic signed [41:0] opv;
  logic signed [31:0] node_v, inv_v;
  logic [31:0]  a_ch, b_ch;
  logic [63:0]  pp;
  logic [104:0] pp_sh;
  logic [74:0]  res;
  logic signed [63:0] accs;
  logic signed [57:0] w58;

  always_comb begin
    if (node_count_i == 4'd0) count_w = CNT_W'(1);
    else if (node_count_i > 4'(MAX_NODES)) count_w = CNT_W'(MAX_NODES);
    else count_w = CNT_W'(node_count_i);
  end
  assign rm1 = IDX_W'(count_w - CNT_W'(1));

  assign den_w = {interval_high_i[31], interval_high_i} - {interval_low_i[31], interval_low_i};
  assign stat_o.count  = count_w;
  assign stat_o.single = count_w == CNT_W'(1);
  assign stat_o.empty  = den_w == 33'sd0;

  always_comb begin
    num_w = {{2{point_value_i[31]}}, point_value_i, 1'b0}
          - ({{3{interval_low_i[31]}}, interval_low_i}
          +  {{3{interval_high_i[31]}}, interval_high_i});
    num_a   = den_w < 0 ? -num_w : num_w;
    den_mag = den_w < 0 ? 33'(-den_w) : 33'(den_w);
    na      = num_a < 0 ? 34'(-num_a) : 34'(num_a);
  end

  assign trial = {rem_q, dsh_q[QUOT_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign rem_d = ge ? 33'(trial - {1'b0, den_q}) : trial[32:0];
  assign tabs  = clamp_q ? (40'd1 << QUOT_W) : {1'b0, quot_q};

  assign node_v = signed'(NODE_ROM[{rm1, cmd_i.k}]);
  assign inv_v  = signed'(INV_ROM[{rm1, cmd_i.j}]);
  assign opv    = cmd_i.op_inv ? {inv_v, 10'd0}
                               : ({t_q[40], t_q} - {{10{node_v[31]}}, node_v});

  assign a_ch = cmd_i.pp_idx[1] ? {1'b0, acc_mag_q[62:32]} : acc_mag_q[31:0];
  assign b_ch = cmd_i.pp_idx[0] ? {22'd0, op_mag_q[41:32]} : op_mag_q[31:0];
  assign pp   = a_ch * b_ch;

  always_comb begin
    case ({1'b0, cmd_i.pp_idx[1]} + {1'b0, cmd_i.pp_idx[0]})
      2'd0:    pp_sh = {41'd0, pp};
      2'd1:    pp_sh = {9'd0, pp, 32'd0};
      2'd2:    pp_sh = {pp[40:0], 64'd0};
      default: pp_sh = '0;
    endcase
  end

  assign res  = prod_q[104:30];
  assign accs = acc_neg_q ? -signed'({1'b0, acc_mag_q}) : signed'({1'b0, acc_mag_q});
  assign w58  = 58'((accs + 64'sd32) >>> 6);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      den_q   <= den_mag;
      neg_q   <= num_a < 0;
      clamp_q <= {8'd0, na} >= {den_mag, 9'd0};
      rem_q   <= {8'd0, na[33:9]};
      dsh_q   <= {na[8:0], 30'd0};
      quot_q  <= '0;
    end else if (cmd_i.div_step) begin
      rem_q  <= rem_d;
      dsh_q  <= {dsh_q[QUOT_W-2:0], 1'b0};
      quot_q <= {quot_q[QUOT_W-2:0], ge};
    end
    if (cmd_i.t_take) t_q <= neg_q ? -signed'({1'b0, tabs}) : signed'({1'b0, tabs});
    if (cmd_i.acc_init) begin
      acc_mag_q <= 63'(ONE_Q30);
      acc_neg_q <= 1'b0;
    end else if (cmd_i.acc_update) begin
      acc_mag_q <= (res > 75'(PROD_CAP)) ? 63'(PROD_CAP) : res[62:0];
      acc_neg_q <= acc_neg_q ^ op_neg_q;
    end
    if (cmd_i.op_load) begin
      op_mag_q <= opv < 0 ? 42'(-opv) : 42'(opv);
      op_neg_q <= opv < 0;
      prod_q   <= '0;
    end else if (cmd_i.pp_step) begin
      prod_q <= prod_q + pp_sh;
    end
    node_index_o <= cmd_i.j;
    last_o       <= cmd_i.last;
    case (cmd_i.out_kind)
      OUT_CALC: begin
        if (w58 > 58'sh7FFF_FFFF) begin
          weight_o    <= 32'sh7FFF_FFFF;
          saturated_o <= 1'b1;
        end else if (w58 < -58'sh8000_0000) begin
          weight_o    <= 32'sh8000_0000;
          saturated_o <= 1'b1;
        end else begin
          weight_o    <= w58[31:0];
          saturated_o <= 1'b0;
        end
      end
      OUT_UNIT: begin
        weight_o    <= 32'sh0100_0000;
        saturated_o <= 1'b0;
      end
      OUT_EMPTY: begin
        weight_o    <= '0;
        saturated_o <= 1'b1;
      end
      default: weight_o <= weight_o;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) result_valid_o <= 1'b0;
    else result_valid_o <= cmd_i.out_kind != OUT_NONE;
  end

endmodule

// ===== sv/chebyshev_lagrange_weights_core.sv =====
`timescale 1ns / 1ps
// Top level of the Chebyshev-Lagrange weight block: configuration registers,
// sequencer and datapath. Depends on clw_pkg, clw_ctrl and clw_datapath.
//
//  Channel   Handshake                      Payload
//  --------  -----------------------------  -------------------------------------------
//  input     start_i, accepted if !busy_o   point_value_i
//  result    result_valid_o strobe, 1 cycle weight_o, node_index_o, saturated_o, last_o
//  config    cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//
// A point first steps the bit-serial divider that forms the normalised coordinate
// and then, per node, forms r-1 plus one products on the single shared 32x32
// multiplier, with bookkeeping states between them. With one node or an empty
// interval the r weights come without the divider or the product loop. Reset
// clears the sequencer and restores the reset interval [-1, 1] with two nodes;
// the tables are constant, so no set-up pass follows. Results cannot be stalled:
// each beat is shown for one cycle.
module chebyshev_lagrange_weights_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [31:0] point_value_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output logic               result_valid_o,
  output logic signed [31:0] weight_o,
  output logic [2:0]         node_index_o,
  output logic               saturated_o,
  output logic               last_o
);
  import clw_pkg::*;

  localparam logic [1:0] REG_LOW   = 2'd0;
  localparam logic [1:0] REG_HIGH  = 2'd1;
  localparam logic [1:0] REG_COUNT = 2'd2;

  logic signed [31:0] interval_low_q, interval_high_q;
  logic [3:0]         node_count_q;
  dp_cmd_t            cmd;
  dp_stat_t           stat;

  // Write configuration only while the block is idle; not enforced, so always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_low_q  <= -32'sd65536;
      interval_high_q <= 32'sd65536;
      node_count_q    <= 4'd2;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_LOW:   interval_low_q  <= cfg_data_i;
        REG_HIGH:  interval_high_q <= cfg_data_i;
        REG_COUNT: node_count_q    <= cfg_data_i[3:0];
        default:   node_count_q    <= node_count_q;
      endcase
    end
  end

  // The sequencer steps the divider, then for each node runs the product loop
  // over the other nodes and finally scales by the stored inverse denominator.
  clw_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .busy_o  (busy_o),
    .cmd_o   (cmd)
  );

  clw_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .interval_low_i  (interval_low_q),
    .interval_high_i (interval_high_q),
    .node_count_i    (node_count_q),
    .point_value_i   (point_value_i),
    .stat_o          (stat),
    .result_valid_o  (result_valid_o),
    .weight_o        (weight_o),
    .node_index_o    (node_index_o),
    .saturated_o     (saturated_o),
    .last_o          (last_o)
  );

endmodule

// ===== bench/clw_tb_pkg.sv =====
`timescale 1ns / 1ps
// Register indexes shared by the weight block's stimulus and its checker.
// Depends on nothing.
package clw_tb_pkg;

  typedef enum logic [1:0] {
    REG_LOW   = 2'd0,
    REG_HIGH  = 2'd1,
    REG_COUNT = 2'd2,
    REG_SPARE = 2'd3
  } clw_reg_e;

endpackage

// ===== bench/clw_weight_checker.sv =====
`timescale 1ns / 1ps
// Checker for the Chebyshev-Lagrange weight block: tracks the register writes,
// predicts the weights of every accepted point and compares each result beat.
// Depends on clw_tb_pkg.
module clw_weight_checker
  import clw_tb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic signed [31:0] point_value_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               result_valid_i,
  input  logic signed [31:0] weight_i,
  input  logic [2:0]         node_index_i,
  input  logic               saturated_i,
  input  logic               last_i,
  output int                 fail_count_o,
  output int                 waiting_o
);

  localparam int NODES = 8;
  localparam longint ONE = 64'sd1 << 30;
  localparam logic [63:0] PI_FIX = 64'd3373259426;
  localparam logic [63:0] CAP = 64'd1 << 62;

  typedef struct {
    logic signed [31:0] weight;
    logic [2:0]         node;
    logic               sat;
    logic               last;
  } weight_beat_t;

  weight_beat_t weight_q[$];
  logic signed [63:0] iv_low, iv_high;
  logic [3:0]         count_reg;
  logic signed [63:0] node_fix [NODES];
  logic signed [63:0] inv_den [NODES];
  int fails;

  assign fail_count_o = fails;
  assign waiting_o    = weight_q.size();

  function automatic logic signed [63:0] fix_mul(logic signed [63:0] a,
                                                 logic signed [63:0] b);
    logic [127:0] p;
    logic [63:0]  ua, ub, res;
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    p  = {64'd0, ua} * {64'd0, ub};
    p  = p >> 30;
    res = (p > {64'd0, CAP}) ? CAP : p[63:0];
    return ((a < 0) != (b < 0)) ? -$signed(res) : $signed(res);
  endfunction

  function automatic logic signed [63:0] cheb_cos(int k, int r);
    logic [63:0] phi, x2, term;
    logic signed [63:0] sum;
    phi  = (PI_FIX * k) / (2 * r);
    x2   = (phi * phi) >> 30;
    term = ONE;
    sum  = ONE;
    for (int n = 1; n <= 8; n++) begin
      term = ((term * x2) >> 30) / ((2 * n - 1) * (2 * n));
      if (n % 2 == 1) sum = sum - $signed(term);
      else sum = sum + $signed(term);
    end
    if (sum < 0) sum = 0;
    if (sum > ONE) sum = ONE;
    return sum;
  endfunction

  function automatic int active_nodes();
    if (count_reg == 0) return 1;
    if (count_reg > NODES) return NODES;
    return count_reg;
  endfunction

  // Rebuilds the standard nodes and their reciprocal denominators (Q12.20).
  task automatic rebuild_tables();
    int r, m;
    logic signed [63:0] d;
    logic [63:0] ud, inv;
    r = active_nodes();
    for (int i = 0; i < NODES; i++) begin
      node_fix[i] = 0;
      inv_den[i]  = 0;
    end
    for (int i = 0; i < r; i++) begin
      m = 2 * i + 1;
      if (m < r) node_fix[i] = cheb_cos(m, r);
      else if (m == r) node_fix[i] = 0;
      else node_fix[i] = -cheb_cos(2 * r - m, r);
    end
    for (int i = 0; i < r; i++) begin
      d = ONE;
      for (int k = 0; k < r; k++)
        if (k != i) d = fix_mul(d, node_fix[i] - node_fix[k]);
      ud = d < 0 ? -d : d;
      if (ud != 0) begin
        inv = ((64'd1 << 50) + ud / 2) / ud;
        if (inv > 64'h7FFF_FFFF) inv = 64'h7FFF_FFFF;
        inv_den[i] = d < 0 ? -$signed(inv) : $signed(inv);
      end
    end
  endtask

  task automatic predict_weights(logic signed [31:0] x);
    int r;
    logic signed [63:0] num, den, t, acc, w;
    logic [63:0] na, q, tabs;
    weight_beat_t b;
    r = active_nodes();
    num = 2 * 64'(x) - (iv_low + iv_high);
    den = iv_high - iv_low;
    if (r == 1) begin
      b = '{32'h0100_0000, 3'd0, 1'b0, 1'b1};
      weight_q.push_back(b);
      return;
    end
    if (den == 0) begin
      // Empty interval: all weights zero and flagged.
      for (int j = 0; j < r; j++) begin
        b = '{32'sd0, 3'(j), 1'b1, j == r - 1};
        weight_q.push_back(b);
      end
      return;
    end
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    na = num < 0 ? -num : num;
    q  = na / den;
    if (q >= 512) tabs = 64'd512 << 30;
    else tabs = (q << 30) + ((na % den) << 30) / den;
    t = num < 0 ? -$signed(tabs) : $signed(tabs);
    for (int j = 0; j < r; j++) begin
      acc = ONE;
      for (int k = 0; k < r; k++)
        if (k != j) acc = fix_mul(acc, t - node_fix[k]);
      acc = fix_mul(acc, inv_den[j] * 1024);
      w = (acc + 32) >>> 6;
      b.sat = 1'b0;
      if (w > 64'sh7FFF_FFFF) begin
        w = 64'sh7FFF_FFFF;
        b.sat = 1'b1;
      end
      if (w < -64'sh8000_0000) begin
        w = -64'sh8000_0000;
        b.sat = 1'b1;
      end
      b.weight = w[31:0];
      b.node   = 3'(j);
      b.last   = (j == r - 1);
      weight_q.push_back(b);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    weight_beat_t e;
    if (!rst_ni) begin
      iv_low    = -64'sd65536;
      iv_high   = 64'sd65536;
      count_reg = 4'd2;
      rebuild_tables();
    end else begin
      if (result_valid_i) begin
        if (weight_q.size() == 0) begin
          $error("result beat with no weight expected");
          fails++;
        end else begin
          e = weight_q.pop_front();
          if (weight_i !== e.weight) begin
            $error("weight: expected %0d, got %0d", e.weight, weight_i);
            fails++;
          end
          if (node_index_i !== e.node) begin
            $error("node_index: expected %0d, got %0d", e.node, node_index_i);
            fails++;
          end
          if (saturated_i !== e.sat) begin
            $error("saturated: expected %0b, got %0b", e.sat, saturated_i);
            fails++;
          end
          if (last_i !== e.last) begin
            $error("last: expected %0b, got %0b", e.last, last_i);
            fails++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (clw_reg_e'(cfg_index_i))
          REG_LOW:   iv_low = $signed(cfg_data_i);
          REG_HIGH:  iv_high = $signed(cfg_data_i);
          REG_COUNT: count_reg = cfg_data_i[3:0];
          default: ;
        endcase
        if (clw_reg_e'(cfg_index_i) != REG_SPARE) rebuild_tables();
      end
      if (start_i && !busy_i) predict_weights(point_value_i);
    end
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the weight block testbench: clock, reset, point and register stimulus.
// Depends on clw_tb_pkg, clw_weight_checker and chebyshev_lagrange_weights_core.
module tb_top;
  import clw_tb_pkg::*;

  logic               clk, rst_n;
  logic               start, busy;
  logic signed [31:0] point;
  logic               cfg_valid, cfg_ready;
  logic [1:0]         cfg_index;
  logic [31:0]        cfg_data;
  logic               res_valid;
  logic signed [31:0] weight;
  logic [2:0]         node_index;
  logic               saturated, last;
  int                 fail_count, waiting;

  // Sender idle percentage for the current phase.
  int gap_pct;
  logic signed [31:0] cur_low, cur_high;

  chebyshev_lagrange_weights_core u_top (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy),
    .point_value_i(point), .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data), .result_valid_o(res_valid),
    .weight_o(weight), .node_index_o(node_index), .saturated_o(saturated),
    .last_o(last)
  );

  clw_weight_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_i(busy),
    .point_value_i(point), .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data), .result_valid_i(res_valid),
    .weight_i(weight), .node_index_i(node_index), .saturated_i(saturated),
    .last_i(last), .fail_count_o(fail_count), .waiting_o(waiting)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  // Offers one point and returns at the edge that accepts it; start stays high
  // so that a following point can go out back to back.
  task automatic send_point(logic signed [31:0] x);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
    start <= 1'b1;
    point <= x;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  // Waits until every expected weight has come and the block has gone quiet.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(clw_reg_e idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_LOW) cur_low = data;
    if (idx == REG_HIGH) cur_high = data;
  endtask

  task automatic set_interval(logic [31:0] lo, logic [31:0] hi, logic [3:0] n);
    drain();
    write_reg(REG_LOW, lo);
    write_reg(REG_HIGH, hi);
    write_reg(REG_COUNT, {28'd0, n});
  endtask

  // Mostly points inside the interval, some anywhere at all.
  function automatic logic signed [31:0] pick_point();
    longint span;
    if ($urandom_range(0, 3) == 0) return $urandom;
    span = longint'(cur_high) - longint'(cur_low);
    return 32'(longint'(cur_low) + ((span * $urandom_range(0, 65536)) >>> 16));
  endfunction

  initial begin
    start     = 1'b0;
    point     = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_LOW;
    cfg_data  = '0;
    gap_pct   = 0;
    cur_low   = -32'sd65536;
    cur_high  = 32'sd65536;
    rst_n     = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part on the reset interval: centre, ends, field extremes.
    send_point(32'sd0);
    send_point(-32'sd65536);
    send_point(32'sd65536);
    send_point(32'sh7FFF_FFFF);
    send_point(32'sh8000_0000);
    send_point(32'sd32768);
    // Single node, zero count treated as one, count above the maximum.
    set_interval(-32'sd65536, 32'sd65536, 4'd1);
    send_point(32'sd12345);
    drain();
    write_reg(REG_COUNT, 32'd0);
    send_point(-32'sd7);
    set_interval(32'sh8000_0000, 32'sh7FFF_FFFF, 4'd15);
    send_point(32'sd0);
    send_point(32'sh7FFF_FFFF);
    send_point(32'sh8000_0000);
    // Empty interval, then a reversed one; the spare index must be ignored.
    set_interval(32'sd65536, 32'sd65536, 4'd3);
    send_point(32'sd65536);
    send_point(-32'sd1);
    set_interval(32'sd131072, -32'sd131072, 4'd4);
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    send_point(32'sd65536);
    send_point(32'sd9999);
    send_point(32'sh4000_0000);
    set_interval(-32'sd65536, 32'sd65536, 4'd8);
    send_point(32'sd0);
    send_point(32'sd65536);
    send_point(32'sd3000);

    // Random part: ten settings, idling varied between phases.
    for (int s = 0; s < 10; s++) begin
      case (s % 4)
        0: gap_pct = 0;
        1: gap_pct = 67;
        2: gap_pct = 0;
        default: gap_pct = 24;
      endcase
      if (s % 3 == 0)
        set_interval($urandom, $urandom, 4'($urandom_range(0, 15)));
      else
        set_interval(-32'($urandom_range(1, 1 << 20)), 32'($urandom_range(1, 1 << 20)),
                     4'($urandom_range(2, 8)));
      for (int n = 0; n < 25; n++) send_point(pick_point());
    end

    drain();
    repeat (500) @(posedge clk);
    if (fail_count == 0 && waiting == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
